// ----- sv/pidc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pidc_pkg;

  localparam int SampleW  = 16;
  localparam int GainW    = 16;
  localparam int StepW    = 16;
  localparam int IntegW   = 48;
  localparam int MulAW    = 17;
  localparam int MulBW    = 33;
  localparam int ProdW    = MulAW + MulBW;
  localparam int AccW     = 50;
  localparam int QuoW     = 48;
  localparam int CntW     = 6;
  localparam int UpcW     = 4;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 16;

  typedef struct packed {
    logic signed [SampleW-1:0] error_sample;
    logic [StepW-1:0]          time_step;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] drive;
    logic                      clamped;
  } out_item_t;

  localparam logic [CfgAddrW-1:0] CFG_PROP_GAIN  = 3'd0;
  localparam logic [CfgAddrW-1:0] CFG_INTEG_GAIN = 3'd1;
  localparam logic [CfgAddrW-1:0] CFG_DERIV_GAIN = 3'd2;
  localparam logic [CfgAddrW-1:0] CFG_OUT_UPPER  = 3'd3;
  localparam logic [CfgAddrW-1:0] CFG_OUT_LOWER  = 3'd4;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_E_STEP,
    MUL_KP_E,
    MUL_KI_HI,
    MUL_KI_LO,
    MUL_KD_DIFF
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADD_SH,
    ACC_ADD_QUO
  } acc_op_t;

  typedef enum logic [2:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_NO_INPUT,
    JMP_STEP_ZERO,
    JMP_CNT_NZ,
    JMP_OUT_BUSY
  } jump_t;

  typedef logic [UpcW-1:0] upc_t;

  localparam upc_t UPC_WAIT   = 4'd0;
  localparam upc_t UPC_MUL_ES = 4'd1;
  localparam upc_t UPC_INTEG  = 4'd2;
  localparam upc_t UPC_PTERM  = 4'd3;
  localparam upc_t UPC_IHI    = 4'd4;
  localparam upc_t UPC_ILO    = 4'd5;
  localparam upc_t UPC_DIV_LD = 4'd6;
  localparam upc_t UPC_DIV_IT = 4'd7;
  localparam upc_t UPC_DTERM  = 4'd8;
  localparam upc_t UPC_EMIT   = 4'd9;
  localparam upc_t UPC_RET    = 4'd10;

  typedef struct packed {
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     ld_in;
    logic     integ_upd;
    logic     div_ld;
    logic     div_it;
    logic     emit;
    jump_t    jmp;
    upc_t     target;
  } ctrl_t;

  function automatic ctrl_t ucode(input upc_t pc);
    ctrl_t cw;
    cw.mul_sel   = MUL_NONE;
    cw.acc_op    = ACC_HOLD;
    cw.ld_in     = 1'b0;
    cw.integ_upd = 1'b0;
    cw.div_ld    = 1'b0;
    cw.div_it    = 1'b0;
    cw.emit      = 1'b0;
    cw.jmp       = JMP_NONE;
    cw.target    = UPC_WAIT;
    case (pc)
      UPC_WAIT: begin
        cw.ld_in  = 1'b1;
        cw.jmp    = JMP_NO_INPUT;
        cw.target = UPC_WAIT;
      end
      UPC_MUL_ES: begin
        cw.mul_sel = MUL_E_STEP;
      end
      UPC_INTEG: begin
        cw.integ_upd = 1'b1;
        cw.mul_sel   = MUL_KP_E;
      end
      UPC_PTERM: begin
        cw.acc_op  = ACC_LOAD;
        cw.mul_sel = MUL_KI_HI;
      end
      UPC_IHI: begin
        cw.acc_op  = ACC_ADD;
        cw.mul_sel = MUL_KI_LO;
      end
      UPC_ILO: begin
        cw.acc_op  = ACC_ADD_SH;
        cw.mul_sel = MUL_KD_DIFF;
      end
      UPC_DIV_LD: begin
        cw.div_ld = 1'b1;
        cw.jmp    = JMP_STEP_ZERO;
        cw.target = UPC_EMIT;
      end
      UPC_DIV_IT: begin
        cw.div_it = 1'b1;
        cw.jmp    = JMP_CNT_NZ;
        cw.target = UPC_DIV_IT;
      end
      UPC_DTERM: begin
        cw.acc_op = ACC_ADD_QUO;
      end
      UPC_EMIT: begin
        cw.emit   = 1'b1;
        cw.jmp    = JMP_OUT_BUSY;
        cw.target = UPC_EMIT;
      end
      UPC_RET: begin
        cw.jmp    = JMP_ALWAYS;
        cw.target = UPC_WAIT;
      end
      default: begin
        cw.jmp    = JMP_ALWAYS;
        cw.target = UPC_WAIT;
      end
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

// ----- sv/pid_controller_clamped.sv -----
// Clamped PID controller, fixed point, driven by a small microprogram.
// Input channel (in_valid / in_stall / in_data): one item per control update,
// an error sample in signed Q8.8 and the elapsed time in unsigned Q0.16 s.
// Result channel (out_valid / out_stall / out_data): one item per input item,
// the clamped drive in signed Q8.8 and a flag set when a limit was applied.
// Configuration port (cfg_we / cfg_addr / cfg_wdata): gains and output limits,
// written while no item is in flight; unknown indexes are dropped.
// A zero time step skips the divider and the derivative term. A new item is
// taken only once the microprogram is back at its wait step. The derivative
// term comes from a 48-step restoring divider; all multiplies share one
// 17 x 33 multiplier, one product per step.
// in_stall is high whenever the microprogram is away from its wait step.
// The result sits in an output register; the next item is accepted while it
// waits, and the program holds at its emit step only if an older result is
// still stalled by the receiver.
// Reset clears the gains, sets the limits to full range, and clears the
// integral and the stored last error; no result is pending after reset.
`timescale 1ns / 1ps
`default_nettype none

module pid_controller_clamped
  import pidc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire in_item_t            in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output out_item_t                out_data,
  input  wire logic                cfg_we,
  input  wire logic [CfgAddrW-1:0] cfg_addr,
  input  wire logic [CfgDataW-1:0] cfg_wdata
);

  upc_t                       upc_r, upc_nxt;
  ctrl_t                      ctrl;

  logic signed [GainW-1:0]    kp_r, kp_nxt;
  logic signed [GainW-1:0]    ki_r, ki_nxt;
  logic signed [GainW-1:0]    kd_r, kd_nxt;
  logic signed [SampleW-1:0]  upper_r, upper_nxt;
  logic signed [SampleW-1:0]  lower_r, lower_nxt;

  logic signed [SampleW-1:0]  e_r, e_nxt;
  logic [StepW-1:0]           step_r, step_nxt;
  logic signed [SampleW-1:0]  last_r, last_nxt;
  logic signed [IntegW-1:0]   integ_r, integ_nxt;

  logic signed [ProdW-1:0]    prod_r, prod_nxt;
  logic signed [AccW-1:0]     acc_r, acc_nxt;
  logic [QuoW-1:0]            quo_r, quo_nxt;
  logic [StepW-1:0]           rem_r, rem_nxt;
  logic [CntW-1:0]            cnt_r, cnt_nxt;
  logic                       neg_r, neg_nxt;

  logic                       out_valid_r, out_valid_nxt;
  out_item_t                  out_r, out_nxt;

  logic signed [MulAW-1:0]    mul_a;
  logic signed [MulBW-1:0]    mul_b;
  logic signed [SampleW:0]    diff;
  logic signed [IntegW:0]     isum;
  logic signed [MulBW-1:0]    num;
  logic [MulBW-1:0]           mag;
  logic [StepW:0]             trial;
  logic                       fits;
  logic signed [AccW-1:0]     quo_s;
  logic signed [AccW-1:0]     upper_q;
  logic signed [AccW-1:0]     lower_q;
  logic                       out_busy;
  logic                       in_fire;
  logic                       take_jump;

  assign in_stall  = (upc_r != UPC_WAIT);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign in_fire   = in_valid && !in_stall;
  assign out_busy  = out_valid_r && out_stall;

  always_comb begin
    ctrl = ucode(upc_r);

    kp_nxt    = kp_r;
    ki_nxt    = ki_r;
    kd_nxt    = kd_r;
    upper_nxt = upper_r;
    lower_nxt = lower_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_PROP_GAIN:  kp_nxt    = cfg_wdata[GainW-1:0];
        CFG_INTEG_GAIN: ki_nxt    = cfg_wdata[GainW-1:0];
        CFG_DERIV_GAIN: kd_nxt    = cfg_wdata[GainW-1:0];
        CFG_OUT_UPPER:  upper_nxt = cfg_wdata[SampleW-1:0];
        CFG_OUT_LOWER:  lower_nxt = cfg_wdata[SampleW-1:0];
        default: ;
      endcase
    end

    e_nxt    = e_r;
    step_nxt = step_r;
    if (ctrl.ld_in && in_fire) begin
      e_nxt    = in_data.error_sample;
      step_nxt = in_data.time_step;
    end

    diff = {e_r[SampleW-1], e_r} - {last_r[SampleW-1], last_r};
    case (ctrl.mul_sel)
      MUL_E_STEP: begin
        mul_a = {e_r[SampleW-1], e_r};
        mul_b = {{(MulBW-StepW){1'b0}}, step_r};
      end
      MUL_KP_E: begin
        mul_a = {kp_r[GainW-1], kp_r};
        mul_b = {{(MulBW-SampleW){e_r[SampleW-1]}}, e_r};
      end
      MUL_KI_HI: begin
        mul_a = {ki_r[GainW-1], ki_r};
        mul_b = {integ_r[IntegW-1], integ_r[IntegW-1:16]};
      end
      MUL_KI_LO: begin
        mul_a = {ki_r[GainW-1], ki_r};
        mul_b = {{(MulBW-16){1'b0}}, integ_r[15:0]};
      end
      MUL_KD_DIFF: begin
        mul_a = {kd_r[GainW-1], kd_r};
        mul_b = {{(MulBW-SampleW-1){diff[SampleW]}}, diff};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = (ctrl.mul_sel == MUL_NONE) ? prod_r : mul_a * mul_b;

    isum      = {integ_r[IntegW-1], integ_r} + prod_r[IntegW:0];
    integ_nxt = integ_r;
    if (ctrl.integ_upd) begin
      if (isum[IntegW] != isum[IntegW-1]) begin
        integ_nxt = isum[IntegW] ? {1'b1, {(IntegW-1){1'b0}}}
                                 : {1'b0, {(IntegW-1){1'b1}}};
      end else begin
        integ_nxt = isum[IntegW-1:0];
      end
    end

    num     = prod_r[MulBW-1:0];
    mag     = num[MulBW-1] ? -num : num;
    trial   = {rem_r, quo_r[QuoW-1]};
    fits    = (trial >= {1'b0, step_r});
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    neg_nxt = neg_r;
    if (ctrl.div_ld) begin
      quo_nxt = {mag[QuoW-17:0], 16'b0};
      rem_nxt = '0;
      cnt_nxt = CntW'(QuoW - 1);
      neg_nxt = num[MulBW-1];
    end else if (ctrl.div_it) begin
      quo_nxt = {quo_r[QuoW-2:0], fits};
      rem_nxt = fits ? StepW'(trial - {1'b0, step_r}) : trial[StepW-1:0];
      cnt_nxt = cnt_r - 1'b1;
    end

    quo_s = neg_r ? -$signed({{(AccW-QuoW){1'b0}}, quo_r})
                  : $signed({{(AccW-QuoW){1'b0}}, quo_r});
    case (ctrl.acc_op)
      ACC_LOAD:    acc_nxt = prod_r;
      ACC_ADD:     acc_nxt = acc_r + prod_r;
      ACC_ADD_SH:  acc_nxt = acc_r + (prod_r >>> 16);
      ACC_ADD_QUO: acc_nxt = acc_r + quo_s;
      default:     acc_nxt = acc_r;
    endcase

    upper_q       = {{(AccW-SampleW-8){upper_r[SampleW-1]}}, upper_r, 8'b0};
    lower_q       = {{(AccW-SampleW-8){lower_r[SampleW-1]}}, lower_r, 8'b0};
    out_nxt       = out_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (ctrl.emit && !out_busy) begin
      out_valid_nxt = 1'b1;
      last_nxt      = e_r;
      if (acc_r > upper_q) begin
        out_nxt.drive   = upper_r;
        out_nxt.clamped = 1'b1;
      end else if (acc_r < lower_q) begin
        out_nxt.drive   = lower_r;
        out_nxt.clamped = 1'b1;
      end else begin
        out_nxt.drive   = acc_r[SampleW+7:8];
        out_nxt.clamped = 1'b0;
      end
    end

    case (ctrl.jmp)
      JMP_ALWAYS:    take_jump = 1'b1;
      JMP_NO_INPUT:  take_jump = !in_valid;
      JMP_STEP_ZERO: take_jump = (step_r == '0);
      JMP_CNT_NZ:    take_jump = (cnt_r != '0);
      JMP_OUT_BUSY:  take_jump = out_busy;
      default:       take_jump = 1'b0;
    endcase
    upc_nxt = take_jump ? ctrl.target : upc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= UPC_WAIT;
      out_valid_r <= 1'b0;
      kp_r        <= '0;
      ki_r        <= '0;
      kd_r        <= '0;
      upper_r     <= {1'b0, {(SampleW-1){1'b1}}};
      lower_r     <= {1'b1, {(SampleW-1){1'b0}}};
      last_r      <= '0;
      integ_r     <= '0;
    end else begin
      upc_r       <= upc_nxt;
      out_valid_r <= out_valid_nxt;
      kp_r        <= kp_nxt;
      ki_r        <= ki_nxt;
      kd_r        <= kd_nxt;
      upper_r     <= upper_nxt;
      lower_r     <= lower_nxt;
      last_r      <= last_nxt;
      integ_r     <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r    <= e_nxt;
    step_r <= step_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    neg_r  <= neg_nxt;
    out_r  <= out_nxt;
  end

endmodule

`default_nettype wire

// ----- verif/pid_drive_checker.sv -----
`timescale 1ns / 1ps

module pid_drive_checker
  import pidc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_stall,
  input  wire in_item_t            in_data,
  input  wire logic                out_valid,
  input  wire logic                out_stall,
  input  wire out_item_t           out_data,
  input  wire logic                cfg_we,
  input  wire logic [CfgAddrW-1:0] cfg_addr,
  input  wire logic [CfgDataW-1:0] cfg_wdata,
  output int                       mismatches,
  output int                       waiting
);

  localparam longint IntegMax = (longint'(1) <<< (IntegW - 1)) - 1;
  localparam longint IntegMin = -IntegMax - 1;
  localparam longint WordMax  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint WordMin  = -WordMax - 1;
  localparam longint QuoLimit = longint'(1) <<< 46;
  localparam longint DerivSat = longint'(1) <<< 62;

  logic signed [GainW-1:0]   kp, ki, kd;
  logic signed [SampleW-1:0] upper, lower, prev_error;
  longint                    integ;
  out_item_t                 drive_q[$];
  int                        fails = 0;

  function automatic longint sat_sum(longint a, longint b, longint lo, longint hi);
    if (b > 0 && a > hi - b) return hi;
    if (b < 0 && a < lo - b) return lo;
    return a + b;
  endfunction

  function automatic longint floor_quot(longint x, longint d);
    if (x >= 0) return x / d;
    return -((-x + d - 1) / d);
  endfunction

  function automatic out_item_t predict_drive(in_item_t it);
    longint    e, dt, pterm, iterm, dterm, sum, num, q, r, lo_part, hi_part;
    out_item_t res;
    e  = longint'($signed(it.error_sample));
    dt = longint'({48'd0, it.time_step});
    integ = sat_sum(integ, e * dt, IntegMin, IntegMax);
    pterm = longint'(kp) * e;
    lo_part = integ & 64'hFFFF;
    hi_part = (integ - lo_part) / 65536;
    iterm = longint'(ki) * hi_part + floor_quot(longint'(ki) * lo_part, 65536);
    dterm = 0;
    if (dt > 0) begin
      num = longint'(kd) * (e - longint'(prev_error));
      q = num / dt;
      r = num % dt;
      if (q >= QuoLimit) dterm = DerivSat;
      else if (q <= -QuoLimit) dterm = -DerivSat;
      else dterm = q * 65536 + (r * 65536) / dt;
    end
    sum = sat_sum(pterm, iterm, WordMin, WordMax);
    sum = sat_sum(sum, dterm, WordMin, WordMax);
    res.clamped = 1'b1;
    if (sum > longint'(upper) * 256) begin
      res.drive = upper;
    end else if (sum < longint'(lower) * 256) begin
      res.drive = lower;
    end else begin
      res.drive   = SampleW'(floor_quot(sum, 256));
      res.clamped = 1'b0;
    end
    prev_error = it.error_sample;
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      kp = '0;
      ki = '0;
      kd = '0;
      upper = 16'sh7FFF;
      lower = 16'sh8000;
      prev_error = '0;
      integ = 0;
      drive_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_PROP_GAIN:  kp = cfg_wdata;
          CFG_INTEG_GAIN: ki = cfg_wdata;
          CFG_DERIV_GAIN: kd = cfg_wdata;
          CFG_OUT_UPPER:  upper = cfg_wdata;
          CFG_OUT_LOWER:  lower = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (drive_q.size() == 0) begin
          if (fails < 10)
            $display("unexpected result: drive %0d clamped %0b",
                     $signed(out_data.drive), out_data.clamped);
          fails++;
        end else begin
          want = drive_q.pop_front();
          if (want.drive !== out_data.drive || want.clamped !== out_data.clamped) begin
            if (fails < 10)
              $display("result mismatch: expected drive %0d clamped %0b, got drive %0d clamped %0b",
                       $signed(want.drive), want.clamped,
                       $signed(out_data.drive), out_data.clamped);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) drive_q.push_back(predict_drive(in_data));
    end
    waiting    <= drive_q.size();
    mismatches <= fails;
  end

endmodule

// ----- verif/pid_controller_clamped_test.sv -----
`timescale 1ns / 1ps

module pid_controller_clamped_test;
  import pidc_pkg::*;

  localparam logic [CfgAddrW-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CfgAddrW-1:0] CFG_SPARE_HI = 3'd7;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_we    = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr  = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                calm      = 1'b0;
  int                  mismatches;
  int                  waiting;
  int                  sent = 0;
  int                  zero_steps = 0;
  int                  settings = 0;

  pid_controller_clamped DUT (.*);

  pid_drive_checker drive_chk (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("pid_controller_clamped_test: errors");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 24);
  end

  task automatic cfg_write(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_controller(input logic [15:0] kp, input logic [15:0] ki,
                                input logic [15:0] kd, input logic [15:0] hi,
                                input logic [15:0] lo);
    cfg_write(CFG_PROP_GAIN, kp);
    cfg_write(CFG_INTEG_GAIN, ki);
    cfg_write(CFG_DERIV_GAIN, kd);
    cfg_write(CFG_OUT_UPPER, hi);
    cfg_write(CFG_OUT_LOWER, lo);
    cfg_write(CfgAddrW'($urandom_range(CFG_SPARE_HI, CFG_SPARE_LO)), 16'($urandom));
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic send(input logic [15:0] err, input logic [15:0] dt);
    while (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{error_sample: err, time_step: dt};
    do @(posedge clk); while (in_stall);
    sent++;
    if (dt == 16'd0) zero_steps++;
  endtask

  // hold until every result is back and the block has returned to its wait step
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_error();
    case ($urandom_range(9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'd0;
      3, 4:    return 16'($urandom_range(64)) - 16'd32;
      5:       return 16'($urandom_range(2048)) - 16'd1024;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_step();
    case ($urandom_range(9))
      0, 1:    return 16'd0;
      2:       return 16'd1;
      3:       return 16'($urandom_range(16, 1));
      4:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'h7FFF;
      2:       return 16'h8000;
      3:       return 16'h0100;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] lim_a, lim_b, lim_t;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero gains, full range
    send(16'h7FFF, 16'hFFFF);
    send(16'h8000, 16'd1);
    send(16'h0000, 16'd0);

    drain();
    set_controller(16'h0100, 16'h0100, 16'h0100, 16'h7FFF, 16'h8000);
    send(16'h0000, 16'd0);
    send(16'h0100, 16'd0);
    send(16'h7FFF, 16'd1);
    send(16'h8000, 16'd1);
    send(16'h8000, 16'hFFFF);
    send(16'h7FFF, 16'hFFFF);
    send(16'h0001, 16'd1);
    send(16'hFFFF, 16'h8000);
    send(16'h0000, 16'd0);

    drain();
    set_controller(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0080, 16'hFF80);
    send(16'h0100, 16'h0100);
    send(16'hFF00, 16'h0100);
    send(16'h0000, 16'd0);
    send(16'h7FFF, 16'd0);

    // upper limit below lower limit
    drain();
    set_controller(16'h0100, 16'h0000, 16'h0000, 16'hFF00, 16'h0100);
    send(16'h0000, 16'd0);
    send(16'h8000, 16'd0);
    send(16'h7FFF, 16'd0);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      lim_a = 16'($urandom);
      lim_b = 16'($urandom);
      if ($signed(lim_a) < $signed(lim_b)) begin
        lim_t = lim_a;
        lim_a = lim_b;
        lim_b = lim_t;
      end
      case (ph)
        0: set_controller(16'h0100, 16'h0020, 16'h0010, 16'h7FFF, 16'h8000);
        1: set_controller(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
        2: set_controller(16'h8000, 16'h8000, 16'h8000, 16'h0100, 16'hFF00);
        3: set_controller(pick_gain(), pick_gain(), pick_gain(), lim_a, lim_b);
        4: set_controller(pick_gain(), pick_gain(), pick_gain(), 16'hFF00, 16'h0100);
        5: set_controller(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        6: set_controller(pick_gain(), pick_gain(), pick_gain(), 16'($urandom), 16'($urandom));
        default: set_controller(pick_gain(), pick_gain(), pick_gain(), 16'h7FFF, 16'h8000);
      endcase
      calm <= (ph == 3);
      for (int n = 0; n < 180; n++) send(pick_error(), pick_step());
    end
    calm <= 1'b0;
    drain();

    $display("%0d items through %0d register settings, %0d of them with a zero time step",
             sent, settings, zero_steps);
    if (mismatches == 0 && waiting == 0) begin
      $display("pid_controller_clamped_test: clean");
    end else begin
      $display("pid_controller_clamped_test: errors");
    end
    $finish;
  end

endmodule
